@@ hdl/sxshuf_pkg.sv @@
// shared constants, types and helper functions for the seeded xorshift shuffle
// no dependencies; imported by sxshuf_mod, seeded_xorshift_shuffle and the testbench
`default_nettype none

package sxshuf_pkg;

  localparam int MAX_POOL = 16;
  localparam int IDX_W    = $clog2(MAX_POOL);
  localparam int CNT_W    = IDX_W + 1;
  localparam int SEED_W   = 32;
  localparam int SIZE_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [SEED_W-1:0] ZERO_SEED_SUBST = 32'hDEADBEEF;
  localparam logic [SEED_W-1:0] SALT_RESET      = 32'h4D555331;
  localparam logic [SIZE_W-1:0] POOL_SIZE_RESET = 5'd15;

  localparam int XS_A = 13;
  localparam int XS_B = 17;
  localparam int XS_C = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_SALT      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 1'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_STEP,
    S_MOD,
    S_RD_I,
    S_RD_J,
    S_WR_I,
    S_WR_J,
    S_LOOK,
    S_RESULT
  } state_t;

  // request to the remainder unit
  typedef struct packed {
    logic              start;
    logic [SEED_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } mod_req_t;

  // answer from the remainder unit
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } mod_rsp_t;

  function automatic logic [SEED_W-1:0] xorshift32(input logic [SEED_W-1:0] x);
    logic [SEED_W-1:0] y;
    y = x ^ (x << XS_A);
    y = y ^ (y >> XS_B);
    y = y ^ (y << XS_C);
    return y;
  endfunction

  // clamp the configured size into 1..MAX_POOL
  function automatic logic [CNT_W-1:0] active_size(input logic [SIZE_W-1:0] sz);
    logic [CNT_W-1:0] n;
    if (sz == '0) begin
      n = CNT_W'(1);
    end else if (32'(sz) > MAX_POOL) begin
      n = CNT_W'(MAX_POOL);
    end else begin
      n = CNT_W'(sz);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ hdl/sxshuf_ram.sv @@
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module sxshuf_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/sxshuf_mod.sv @@
// bit-serial restoring remainder unit: 32-bit dividend by a small divisor
// depends on sxshuf_pkg
`default_nettype none

module sxshuf_mod
  import sxshuf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mod_req_t req,
  output mod_rsp_t      rsp
);

  localparam int STEP_W = $clog2(SEED_W);

  logic              active;
  logic              done;
  logic [STEP_W-1:0] cnt;
  logic [SEED_W-1:0] shreg;
  logic [CNT_W-1:0]  divisor;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  trial;
  logic [CNT_W-1:0]  rem_next;

  // rem stays below divisor (at most MAX_POOL), so its low bits plus one new bit fit
  assign trial    = {rem[IDX_W-1:0], shreg[SEED_W-1]};
  assign rem_next = (trial >= divisor) ? (trial - divisor) : trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        cnt    <= STEP_W'(SEED_W - 1);
      end else if (active) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      shreg   <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
    end else if (active) begin
      shreg <= {shreg[SEED_W-2:0], 1'b0};
      rem   <= rem_next;
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem[IDX_W-1:0];

endmodule

`default_nettype wire

@@ hdl/seeded_xorshift_shuffle.sv @@
// seeded pool shuffle: remaps a pool index through a fisher-yates permutation
// driven by xorshift32; depends on sxshuf_pkg, sxshuf_ram and sxshuf_mod
//
// usage:
//   input beat (in_valid/in_ready) carries seed and pool_index; one output beat
//   (out_valid/out_ready) carries mapped_index for every input beat, in order.
//   cfg_write/cfg_index/cfg_data set salt (index 0) and pool_size (index 1);
//   write them only while the block is idle.
//   an index with an unchanged seed, or one outside the pool, goes from idle
//   straight to the result state, which loads the output register.
//   a new seed rebuilds the permutation first: the fill state writes the identity,
//   then n-1 swaps, each of one xorshift step, a remainder in the bit-serial
//   remainder unit, ram reads of i and j and writes to i and j; then a lookup.
//   the remainder unit and the table's single read port set a swap's length.
//   in_ready is high only while the sequencer is idle.
//   reset clears the built flag and restores salt and pool_size; the table
//   itself needs no clearing since the first in-pool item always rebuilds it.
//   a stalled receiver holds the output register; the block may accept one
//   more item and then waits in its result state until the beat is taken.
`default_nettype none

module seeded_xorshift_shuffle
  import sxshuf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [SEED_W-1:0]     seed,
  input  wire logic [IDX_W-1:0]      pool_index,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [IDX_W-1:0]           mapped_index
);

  state_t state;
  state_t state_next;

  logic [SEED_W-1:0] salt;
  logic [SIZE_W-1:0] pool_size;

  logic [SEED_W-1:0] gen;
  logic [SEED_W-1:0] built_seed;
  logic              built_valid;
  logic [SEED_W-1:0] seed_q;
  logic [IDX_W-1:0]  idx_q;
  logic [CNT_W-1:0]  n_q;
  logic              pass_q;
  logic [IDX_W-1:0]  i_q;
  logic [IDX_W-1:0]  j_q;
  logic [IDX_W-1:0]  a_q;

  logic [CNT_W-1:0]  n_in;
  logic              pass_in;
  logic              need_build;
  logic              accept;
  logic              fill_last;
  logic              out_load;
  logic [SEED_W-1:0] mixed;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [IDX_W-1:0]  ram_rdata;

  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  assign n_in       = active_size(pool_size);
  assign pass_in    = {1'b0, pool_index} >= n_in;
  assign need_build = !pass_in && (!built_valid || (seed != built_seed));
  assign accept     = in_valid && in_ready;
  assign fill_last  = {1'b0, i_q} == (n_q - CNT_W'(1));
  assign out_load   = (state == S_RESULT) && (!out_valid || out_ready);
  assign mixed      = seed_q ^ salt;

  sxshuf_ram #(
    .WIDTH(IDX_W),
    .DEPTH(MAX_POOL)
  ) u_perm (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  sxshuf_mod u_mod (
    .clk(clk),
    .rst(rst),
    .req(mod_req),
    .rsp(mod_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = need_build ? S_FILL : S_RESULT;
        end
      end
      S_FILL: begin
        if (fill_last) begin
          state_next = (n_q == CNT_W'(1)) ? S_LOOK : S_STEP;
        end
      end
      S_STEP: state_next = S_MOD;
      S_MOD: begin
        if (mod_rsp.done) begin
          state_next = S_RD_I;
        end
      end
      S_RD_I: state_next = S_RD_J;
      S_RD_J: state_next = S_WR_I;
      S_WR_I: state_next = S_WR_J;
      S_WR_J: state_next = (i_q == IDX_W'(1)) ? S_LOOK : S_STEP;
      S_LOOK: state_next = S_RESULT;
      S_RESULT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready         = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = i_q;
    ram_wdata        = i_q;
    ram_raddr        = idx_q;
    mod_req.start    = 1'b0;
    mod_req.dividend = xorshift32(gen);
    mod_req.divisor  = {1'b0, i_q} + CNT_W'(1);
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = pool_index;
      end
      S_FILL: ram_we = 1'b1;
      S_STEP: mod_req.start = 1'b1;
      S_RD_I: ram_raddr = i_q;
      S_RD_J: ram_raddr = j_q;
      S_WR_I: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      S_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = a_q;
      end
      default: begin
        ram_raddr = idx_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      salt        <= SALT_RESET;
      pool_size   <= POOL_SIZE_RESET;
      built_seed  <= '0;
      built_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          CFG_SALT:      salt      <= cfg_data;
          CFG_POOL_SIZE: pool_size <= cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
      if ((state == S_FILL && fill_last && n_q == CNT_W'(1)) ||
          (state == S_WR_J && i_q == IDX_W'(1))) begin
        built_seed  <= seed_q;
        built_valid <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      seed_q <= seed;
      idx_q  <= pool_index;
      n_q    <= n_in;
      pass_q <= pass_in;
      i_q    <= '0;
    end
    case (state)
      S_FILL: begin
        if (fill_last) begin
          i_q <= IDX_W'(n_q - CNT_W'(1));
          gen <= (mixed != '0) ? mixed : ZERO_SEED_SUBST;
        end else begin
          i_q <= i_q + IDX_W'(1);
        end
      end
      S_STEP: gen <= xorshift32(gen);
      S_MOD: begin
        if (mod_rsp.done) begin
          j_q <= mod_rsp.rem;
        end
      end
      S_RD_J: a_q <= ram_rdata;
      S_WR_J: i_q <= i_q - IDX_W'(1);
      default: ;
    endcase
    if (out_load) begin
      mapped_index <= pass_q ? idx_q : ram_rdata;
    end
  end

  // remainder answers arrive only while the sequencer waits for them
  assert property (@(posedge clk) disable iff (rst) mod_rsp.done |-> state == S_MOD)
    else $error("remainder done outside wait state");

  // swap partner never lies above the current top index
  assert property (@(posedge clk) disable iff (rst) state == S_RD_J |-> j_q <= i_q)
    else $error("swap index beyond current position");

  // a built permutation stays built
  assert property (@(posedge clk) disable iff (rst) built_valid |=> built_valid)
    else $error("built flag dropped");

  // a result beat only starts out of the result state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_RESULT)
    else $error("output beat raised outside result state");

endmodule

`default_nettype wire

@@ sim/tb_seeded_xorshift_shuffle.sv @@
// testbench for seeded_xorshift_shuffle: predicts every remapped index from its own
// fisher-yates/xorshift32 shuffle model and checks the output beats in order
// depends on sxshuf_pkg and the seeded_xorshift_shuffle rtl
`timescale 1ns / 1ps

module tb_seeded_xorshift_shuffle;
  import sxshuf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned PHASE_ITEMS = 120;
  localparam int unsigned PHASES      = 12;

  typedef enum int unsigned {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  // keeps a shadow of the pool permutation and the mapped indexes still owed
  class remap_checker;
    bit [31:0] salt;
    bit [4:0]  pool_size;
    bit [31:0] rng;
    bit [3:0]  perm [MAX_POOL];
    bit        filled [MAX_POOL];
    bit [31:0] built_seed;
    bit        built;
    bit [3:0]  mapped_due [$];
    int        faults;

    function new();
      salt       = SALT_RESET;
      pool_size  = POOL_SIZE_RESET;
      rng        = '0;
      built_seed = '0;
      built      = 1'b0;
      faults     = 0;
      foreach (perm[k]) begin
        perm[k]   = '0;
        filled[k] = 1'b0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      if (idx == CFG_SALT) begin
        salt = data;
      end else if (idx == CFG_POOL_SIZE) begin
        pool_size = data[4:0];
      end
    endfunction

    function int unsigned span();
      if (pool_size == 0) return 1;
      if (pool_size > MAX_POOL) return MAX_POOL;
      return 32'(pool_size);
    endfunction

    // true when this beat would look up a table entry no shuffle ever wrote
    function bit hits_unfilled(bit [31:0] s, bit [3:0] idx);
      return (idx < span()) && built && (s == built_seed) && !filled[idx];
    endfunction

    function void note_input(bit [31:0] s, bit [3:0] idx);
      int unsigned n;
      int unsigned i;
      int unsigned j;
      bit [3:0]    t;
      n = span();
      if (idx >= n) begin
        mapped_due.push_back(idx);
        return;
      end
      if (!built || s != built_seed) begin
        for (i = 0; i < n; i++) begin
          perm[i]   = i[3:0];
          filled[i] = 1'b1;
        end
        rng = ((s ^ salt) != 0) ? (s ^ salt) : ZERO_SEED_SUBST;
        // top-down swap pass
        for (i = n - 1; i > 0; i--) begin
          rng = rng ^ (rng << 13);
          rng = rng ^ (rng >> 17);
          rng = rng ^ (rng << 5);
          j = rng % (i + 1);
          t = perm[i];
          perm[i] = perm[j];
          perm[j] = t;
        end
        built_seed = s;
        built      = 1'b1;
      end
      mapped_due.push_back(perm[idx]);
    endfunction

    function void check_result(logic [3:0] got);
      bit [3:0] want;
      if (mapped_due.size() == 0) begin
        faults++;
        if (faults <= 10) $display("output beat with nothing owed: mapped_index=%0d", got);
        return;
      end
      want = mapped_due.pop_front();
      if (got !== want) begin
        faults++;
        if (faults <= 10) $display("mapped_index mismatch: expected %0d, actual %0d", want, got);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SEED_W-1:0]     seed = '0;
  logic [IDX_W-1:0]      pool_index = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [IDX_W-1:0]      mapped_index;

  remap_checker sb;
  int unsigned  burst_left = 0;
  int unsigned  cycles = 0;
  int unsigned  rx_tick = 0;
  rx_mode_t     rx_mode = RX_OPEN;

  seeded_xorshift_shuffle u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .seed         (seed),
    .pool_index   (pool_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mapped_index (mapped_index)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver backpressure, in a mode that is rechosen at random
  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 300 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:  out_ready <= 1'b1;
      RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_ready <= ($urandom_range(0, 9) < 3);
      default:  out_ready <= ((rx_tick % 7) < 3);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(mapped_index);
  end

  task automatic send_item(bit [31:0] s, bit [3:0] idx);
    int unsigned gap;
    @(negedge clk);
    in_valid   <= 1'b1;
    seed       <= s;
    pool_index <= idx;
    do @(posedge clk); while (!in_ready);
    sb.note_input(s, idx);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // stop sending and wait for every owed beat
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.mapped_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int unsigned phase_size [PHASES];
    bit [31:0]   run_seed;
    bit [31:0]   old_seed;
    bit [31:0]   s;
    bit [31:0]   tmp;
    bit [3:0]    idx;
    int unsigned roll;
    int unsigned n;

    phase_size = '{2, 5, 16, 3, 1, 8, 0, 4, 31, 6, 12, 7};
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // first beat must build even though seed matches the cleared stored seed
    send_item(32'h0, 4'd0);
    send_item(32'h0, 4'd14);
    send_item(32'h0, 4'd15);
    // seed equal to salt gives a zero generator seed
    send_item(SALT_RESET, 4'd3);
    send_item(SALT_RESET, 4'd9);
    send_item(32'hFFFF_FFFF, 4'd7);
    send_item(32'hFFFF_FFFF, 4'd15);

    drain();
    set_reg(CFG_SALT, 32'h0);
    set_reg(CFG_POOL_SIZE, 32'd16);
    send_item(32'h0, 4'd15);
    send_item(32'h0, 4'd0);
    send_item(32'hFFFF_FFFF, 4'd15);

    // salt changed, seed kept: old table stays
    drain();
    set_reg(CFG_SALT, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 4'd15);
    send_item(32'hFFFF_FFFF, 4'd8);

    // size zero acts as a single entry
    drain();
    set_reg(CFG_POOL_SIZE, 32'd0);
    send_item(32'hFFFF_FFFF, 4'd0);
    send_item(32'hFFFF_FFFF, 4'd1);
    send_item(32'h0, 4'd0);

    // oversized pool clamps to the full table
    drain();
    set_reg(CFG_POOL_SIZE, 32'd31);
    send_item(32'h0, 4'd15);
    send_item(32'h5A5A_5A5A, 4'd15);
    send_item(32'h5A5A_5A5A, 4'd0);

    old_seed = 32'h0;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      set_reg(CFG_SALT, (ph == 0) ? 32'h0 : (ph == 1) ? 32'hFFFF_FFFF : $urandom);
      set_reg(CFG_POOL_SIZE, phase_size[ph]);
      run_seed = $urandom;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          old_seed = run_seed;
          run_seed = $urandom;
        end else if (roll < 10) begin
          // go back to an earlier run
          tmp      = old_seed;
          old_seed = run_seed;
          run_seed = tmp;
        end else if (roll < 11) begin
          run_seed = sb.salt;
        end
        n = sb.span();
        if ($urandom_range(0, 9) != 0) begin
          idx = 4'($urandom_range(0, n - 1));
        end else begin
          idx = 4'($urandom_range(0, 15));
        end
        s   = run_seed;
        if ($urandom_range(0, 49) == 0) s = $urandom;
        if (sb.hits_unfilled(s, idx)) begin
          run_seed = $urandom;
          s        = run_seed;
        end
        send_item(s, idx);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.faults == 0 && sb.mapped_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
